// ===== hdl/assert_macros.svh =====
// Assertion macros for the heap RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define IHP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define IHP_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("check failed");
`else
`define IHP_ASSERT(lbl, clk, rst_n, prop)
`define IHP_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/ihp_pkg.sv =====
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types, codes and key ordering for the indexed max-heap.
// ----------------------------------------------------------------------------
`default_nettype none
package ihp_pkg;
	localparam int unsigned HEAP_DEPTH_DEF = 1024;
	localparam int KEY_W = 32;

	typedef logic [1:0] op_t;
	localparam op_t OP_INS    = 2'd0;
	localparam op_t OP_UPD    = 2'd1;
	localparam op_t OP_FULL   = 2'd2;
	localparam op_t OP_BADPOS = 2'd3;

	typedef logic [1:0] status_t;
	localparam status_t STATUS_DONE   = 2'd0;
	localparam status_t STATUS_FULL   = 2'd1;
	localparam status_t STATUS_BADPOS = 2'd2;

	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

	function automatic logic key_less(input logic signed [KEY_W-1:0] a,
			input logic signed [KEY_W-1:0] b);
		return a < b;
	endfunction
endpackage
`default_nettype wire

// ===== hdl/ihp_front.sv =====
// ----------------------------------------------------------------------------
// ihp_front
// Accepts words, checks them against a running count, queues them (2 deep).
// ----------------------------------------------------------------------------
`default_nettype none
module ihp_front #(
	parameter int unsigned HEAP_DEPTH = ihp_pkg::HEAP_DEPTH_DEF,
	parameter int unsigned SLOT_W     = $clog2(HEAP_DEPTH + 1)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic signed [ihp_pkg::KEY_W-1:0]  new_key,
	input  wire logic [SLOT_W-1:0]                 position,
	output logic                                   q_valid,
	input  wire logic                              q_ready,
	output ihp_pkg::cmd_t                          q_cmd,
	output logic [SLOT_W-1:0]                      q_slot,
	output logic [SLOT_W-1:0]                      q_count
);
	localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(HEAP_DEPTH);

	logic [SLOT_W-1:0] count_q, cnt_next, slot_c;
	ihp_pkg::op_t      op_c;
	ihp_pkg::cmd_t     fifo_cmd_q [2];
	logic [SLOT_W-1:0] fifo_slot_q [2];
	logic [SLOT_W-1:0] fifo_cnt_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        fill_q;
	logic              push, pop;

	// count tracks the back end exactly: it depends only on the command order
	always_comb begin
		cnt_next = count_q;
		if (cmd == 1'b0) begin
			if (count_q == DEPTH_S) begin
				op_c = ihp_pkg::OP_FULL;
			end else begin
				op_c     = ihp_pkg::OP_INS;
				cnt_next = count_q + 1'b1;
			end
			slot_c = cnt_next;
		end else begin
			if (position == '0 || position > count_q) begin
				op_c = ihp_pkg::OP_BADPOS;
			end else begin
				op_c = ihp_pkg::OP_UPD;
			end
			slot_c = position;
		end
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (fill_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = fifo_cmd_q[rd_ptr_q];
	assign q_slot   = fifo_slot_q[rd_ptr_q];
	assign q_count  = fifo_cnt_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_cmd_q[wr_ptr_q]  <= '{op: op_c, key: new_key};
			fifo_slot_q[wr_ptr_q] <= slot_c;
			fifo_cnt_q[wr_ptr_q]  <= cnt_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				count_q  <= cnt_next;
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hdl/ihp_back.sv =====
// ----------------------------------------------------------------------------
// ihp_back
// Sift sequencer over the slot memory, root copy and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ihp_back #(
	parameter int unsigned HEAP_DEPTH = ihp_pkg::HEAP_DEPTH_DEF,
	parameter int unsigned SLOT_W     = $clog2(HEAP_DEPTH + 1),
	parameter int unsigned ITEM_W     = $clog2(HEAP_DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire ihp_pkg::cmd_t                     q_cmd,
	input  wire logic [SLOT_W-1:0]                 q_slot,
	input  wire logic [SLOT_W-1:0]                 q_count,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             status,
	output logic signed [ihp_pkg::KEY_W-1:0]       top_key,
	output logic [ITEM_W-1:0]                      top_item,
	output logic [SLOT_W-1:0]                      entry_count,
	output logic [ITEM_W-1:0]                      moved_item,
	output logic [SLOT_W-1:0]                      moved_slot
);
	localparam int KW  = ihp_pkg::KEY_W;
	localparam int EW  = KW + ITEM_W;
	localparam int CW  = SLOT_W + 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_ULD    = 3'd1;
	localparam logic [2:0] S_UP_RD  = 3'd2;
	localparam logic [2:0] S_UP_CMP = 3'd3;
	localparam logic [2:0] S_DN_RD  = 3'd4;
	localparam logic [2:0] S_DN_CMP = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	// memory word: {key, item}; entry a holds slot a+1
	logic [EW-1:0]       mem_q [HEAP_DEPTH];
	logic [EW-1:0]       rd0_q, rd1_q;
	logic [ITEM_W-1:0]   ra0, ra1, wa;
	logic [EW-1:0]       wd, kid;
	logic                we;

	logic [2:0]          state_q;
	logic signed [KW-1:0] key_q, root_key_q;
	logic [ITEM_W-1:0]   item_q, root_item_q;
	logic [SLOT_W-1:0]   s_q, n_q;
	ihp_pkg::status_t    status_q;
	logic                moved_q;

	logic [CW-1:0]       c, n_ext, kid_slot;
	logic                up_less, pick1, sink_go, c_in_heap;

	always_comb begin
		c         = {s_q, 1'b0};
		n_ext     = {1'b0, n_q};
		c_in_heap = (c <= n_ext);
		up_less   = ihp_pkg::key_less(rd0_q[EW-1 -: KW], key_q);
		pick1     = (c < n_ext) && ihp_pkg::key_less(rd0_q[EW-1 -: KW], rd1_q[EW-1 -: KW]);
		kid       = pick1 ? rd1_q : rd0_q;
		kid_slot  = pick1 ? c + 1'b1 : c;
		sink_go   = ihp_pkg::key_less(key_q, kid[EW-1 -: KW]);

		we  = 1'b0;
		wa  = ITEM_W'(s_q - 1'b1);
		wd  = {key_q, item_q};
		ra0 = ITEM_W'(s_q - 1'b1);
		ra1 = ITEM_W'(c);
		case (state_q)
			S_IDLE: begin
				ra0 = ITEM_W'(q_slot - 1'b1);
			end
			S_UP_RD: begin
				if (s_q == SLOT_W'(1)) begin
					we = 1'b1;
				end else begin
					ra0 = ITEM_W'((s_q >> 1) - 1'b1);
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (up_less) begin
					wd = rd0_q;
				end
			end
			S_DN_RD: begin
				ra0 = ITEM_W'(c - 1'b1);
				if (!c_in_heap) begin
					we = 1'b1;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (sink_go) begin
					wd = kid;
				end
			end
			default: begin
			end
		endcase
	end

	assign q_ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd0_q <= mem_q[ra0];
		rd1_q <= mem_q[ra1];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			n_q   <= q_count;
			key_q <= q_cmd.key;
			s_q   <= q_slot;
			// an inserted slot was never written: it still holds its own item
			item_q <= ITEM_W'(q_count - 1'b1);
		end else if (state_q == S_ULD) begin
			item_q <= rd0_q[ITEM_W-1:0];
		end else if (state_q == S_UP_CMP && up_less) begin
			s_q <= s_q >> 1;
		end else if (state_q == S_DN_CMP && sink_go) begin
			s_q <= SLOT_W'(kid_slot);
		end
		if (state_q == S_OUT && (!out_valid || out_ready)) begin
			status      <= status_q;
			top_key     <= root_key_q;
			top_item    <= root_item_q;
			entry_count <= n_q;
			moved_item  <= moved_q ? item_q : '0;
			moved_slot  <= moved_q ? s_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= ihp_pkg::STATUS_DONE;
			moved_q     <= 1'b0;
			root_key_q  <= '0;
			root_item_q <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (we && wa == '0) begin
				root_key_q  <= wd[EW-1 -: KW];
				root_item_q <= wd[ITEM_W-1:0];
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						status_q <= ihp_pkg::STATUS_DONE;
						moved_q  <= 1'b1;
						case (q_cmd.op)
							ihp_pkg::OP_INS: state_q <= S_UP_RD;
							ihp_pkg::OP_UPD: state_q <= S_ULD;
							ihp_pkg::OP_FULL: begin
								status_q <= ihp_pkg::STATUS_FULL;
								moved_q  <= 1'b0;
								state_q  <= S_OUT;
							end
							default: begin
								status_q <= ihp_pkg::STATUS_BADPOS;
								moved_q  <= 1'b0;
								state_q  <= S_OUT;
							end
						endcase
					end
				end
				S_ULD: begin
					state_q <= up_less ? S_UP_RD : S_DN_RD;
				end
				S_UP_RD: begin
					state_q <= (s_q == SLOT_W'(1)) ? S_OUT : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= up_less ? S_UP_RD : S_OUT;
				end
				S_DN_RD: begin
					state_q <= c_in_heap ? S_DN_CMP : S_OUT;
				end
				S_DN_CMP: begin
					state_q <= sink_go ? S_DN_RD : S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`IHP_ASSERT(a_up_cmp_below_root, clk, arst_n, (state_q == S_UP_CMP) |-> (s_q > SLOT_W'(1)))
	`IHP_ASSERT(a_dn_child_in_heap, clk, arst_n, (state_q == S_DN_CMP) |-> c_in_heap)
	`IHP_NEVER(a_hole_not_zero, clk, arst_n, (state_q != S_IDLE) && (state_q != S_OUT) && (s_q == '0))
	`IHP_ASSERT(a_write_in_heap, clk, arst_n, we |-> ({1'b0, wa} < n_q))
endmodule
`default_nettype wire

// ===== hdl/indexed_max_heap_top.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_top
// Binary max-heap of preallocated items with insert and key update.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): cmd 0 inserts new_key as the item that
// sits in the next free slot; cmd 1 sets new_key at heap slot position.
// Output channel (out_valid/out_ready): one word per input word, carrying
// status, root key and item, entry count, and the moved item and its slot.
// A two-word queue sits between the front checker and the sift engine, so
// words are taken while the engine works or the output waits.
// Before the output handshake, errors go straight to the output stage; an
// insert climbs level by level, and an update first loads the moved item,
// then climbs or sinks level by level.
// One word is sifted at a time; throughput is set by the sift loop, one
// memory read and one compare-and-write per level.
// Reset: heap empty, root reads as zero; no memory clearing is needed.
// A stalled receiver holds the output word; the engine then waits, and the
// queue fills before in_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_max_heap_top #(
	parameter int unsigned HEAP_DEPTH = ihp_pkg::HEAP_DEPTH_DEF,
	localparam int unsigned SLOT_W    = $clog2(HEAP_DEPTH + 1),
	localparam int unsigned ITEM_W    = $clog2(HEAP_DEPTH)
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              cmd,
	input  wire logic signed [ihp_pkg::KEY_W-1:0]  new_key,
	input  wire logic [SLOT_W-1:0]                 position,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             status,
	output logic signed [ihp_pkg::KEY_W-1:0]       top_key,
	output logic [ITEM_W-1:0]                      top_item,
	output logic [SLOT_W-1:0]                      entry_count,
	output logic [ITEM_W-1:0]                      moved_item,
	output logic [SLOT_W-1:0]                      moved_slot
);
	logic              q_valid, q_ready;
	ihp_pkg::cmd_t     q_cmd;
	logic [SLOT_W-1:0] q_slot, q_count;

	ihp_front #(.HEAP_DEPTH(HEAP_DEPTH), .SLOT_W(SLOT_W)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .new_key(new_key), .position(position),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .q_slot(q_slot), .q_count(q_count)
	);

	ihp_back #(.HEAP_DEPTH(HEAP_DEPTH), .SLOT_W(SLOT_W), .ITEM_W(ITEM_W)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .q_slot(q_slot), .q_count(q_count),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_key(top_key), .top_item(top_item),
		.entry_count(entry_count), .moved_item(moved_item), .moved_slot(moved_slot)
	);
endmodule
`default_nettype wire

// ===== verif/ihp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihp_checker
// Watches both channels of the indexed max-heap. It keeps its own copy of the
// heap, works out the result word for every accepted input word, and checks
// each output word in order, field by field.
// ----------------------------------------------------------------------------
module ihp_checker #(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               cmd,
	input  wire logic signed [31:0] new_key,
	input  wire logic [10:0]        position,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [1:0]         status,
	input  wire logic signed [31:0] top_key,
	input  wire logic [9:0]         top_item,
	input  wire logic [10:0]        entry_count,
	input  wire logic [9:0]         moved_item,
	input  wire logic [10:0]        moved_slot,
	output int                      errors,
	output int                      outstanding
);
	localparam logic CMD_INSERT = ihp_pkg::OP_INS[0];

	typedef struct {
		ihp_pkg::status_t   st;
		logic signed [31:0] root_key;
		logic [9:0]         root_item;
		logic [10:0]        count;
		logic [9:0]         item;
		logic [10:0]        slot;
	} heap_word_t;

	logic signed [31:0] heap_keys [1:DEPTH];
	logic [9:0]         heap_items [1:DEPTH];
	int unsigned        heap_n;
	heap_word_t         expected_words [$];

	function automatic int unsigned climb(int unsigned s);
		logic signed [31:0] k;
		logic [9:0]         it;
		k  = heap_keys[s];
		it = heap_items[s];
		while (s > 1 && heap_keys[s >> 1] < k) begin
			heap_keys[s]  = heap_keys[s >> 1];
			heap_items[s] = heap_items[s >> 1];
			s = s >> 1;
		end
		heap_keys[s]  = k;
		heap_items[s] = it;
		return s;
	endfunction

	function automatic int unsigned descend(int unsigned s);
		logic signed [31:0] k;
		logic [9:0]         it;
		int unsigned        c;
		k  = heap_keys[s];
		it = heap_items[s];
		forever begin
			c = 2 * s;
			if (c > heap_n)
				break;
			if (c < heap_n && heap_keys[c] < heap_keys[c + 1])
				c++;
			if (!(k < heap_keys[c]))
				break;
			heap_keys[s]  = heap_keys[c];
			heap_items[s] = heap_items[c];
			s = c;
		end
		heap_keys[s]  = k;
		heap_items[s] = it;
		return s;
	endfunction

	function automatic heap_word_t apply_word(logic c, logic signed [31:0] k,
			logic [10:0] p);
		heap_word_t w;
		logic       up;
		w.st   = ihp_pkg::STATUS_DONE;
		w.item = '0;
		w.slot = '0;
		if (c == CMD_INSERT) begin
			if (heap_n >= DEPTH) begin
				w.st = ihp_pkg::STATUS_FULL;
			end else begin
				heap_n++;
				heap_keys[heap_n] = k;
				w.item = heap_items[heap_n];
				w.slot = 11'(climb(heap_n));
			end
		end else if (p == 0 || p > heap_n) begin
			w.st = ihp_pkg::STATUS_BADPOS;
		end else begin
			up = heap_keys[p] < k;
			heap_keys[p] = k;
			w.item = heap_items[p];
			w.slot = 11'(up ? climb(p) : descend(p));
		end
		w.root_key  = heap_n ? heap_keys[1] : '0;
		w.root_item = heap_n ? heap_items[1] : '0;
		w.count     = 11'(heap_n);
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		heap_word_t w;
		if (!arst_n) begin
			for (int s = 1; s <= DEPTH; s++) begin
				heap_keys[s]  = '0;
				heap_items[s] = 10'(s - 1);
			end
			heap_n = 0;
			errors = 0;
			expected_words.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("output word with nothing expected");
					errors++;
				end else begin
					w = expected_words.pop_front();
					if (status !== w.st) begin
						$error("status: expected %0d, got %0d", w.st, status);
						errors++;
					end
					if (top_key !== w.root_key) begin
						$error("top_key: expected %0d, got %0d", w.root_key, top_key);
						errors++;
					end
					if (top_item !== w.root_item) begin
						$error("top_item: expected %0d, got %0d", w.root_item, top_item);
						errors++;
					end
					if (entry_count !== w.count) begin
						$error("entry_count: expected %0d, got %0d", w.count, entry_count);
						errors++;
					end
					if (moved_item !== w.item) begin
						$error("moved_item: expected %0d, got %0d", w.item, moved_item);
						errors++;
					end
					if (moved_slot !== w.slot) begin
						$error("moved_slot: expected %0d, got %0d", w.slot, moved_slot);
						errors++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_words.push_back(apply_word(cmd, new_key, position));
			outstanding = expected_words.size();
		end
	end
endmodule

// ===== verif/tb_indexed_max_heap_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_max_heap_top
// Drives inserts and key updates into the indexed max-heap: a directed opening
// on the corner cases, then random traffic that fills the heap to capacity.
// Both channels idle at random and the receiver stalls once for a long spell.
// ----------------------------------------------------------------------------
module tb_indexed_max_heap_top;
	localparam int unsigned DEPTH = 1024;
	localparam logic CMD_INSERT = ihp_pkg::OP_INS[0];
	localparam logic CMD_UPDATE = ihp_pkg::OP_UPD[0];
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic signed [31:0] new_key;
	logic [10:0]        position;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic signed [31:0] top_key;
	logic [9:0]         top_item;
	logic [10:0]        entry_count;
	logic [9:0]         moved_item;
	logic [10:0]        moved_slot;
	int                 errors;
	int                 outstanding;

	bit                 idle_on = 1'b1;
	int unsigned        fill = 0;
	int unsigned        sent = 0;
	int unsigned        received = 0;
	int unsigned        full_hits = 0;
	int unsigned        bad_hits = 0;

	indexed_max_heap_top #(.HEAP_DEPTH(DEPTH)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .new_key(new_key), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_key(top_key), .top_item(top_item),
		.entry_count(entry_count), .moved_item(moved_item), .moved_slot(moved_slot)
	);

	ihp_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .new_key(new_key), .position(position),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .top_key(top_key), .top_item(top_item),
		.entry_count(entry_count), .moved_item(moved_item), .moved_slot(moved_slot),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off once traffic flows
	initial begin
		int unsigned hold;
		bit          held;
		hold = 0;
		held = 1'b0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				received++;
			if (!held && received == 200) begin
				held = 1'b1;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !idle_on || $urandom_range(0, 99) >= 38;
			end
		end
	end

	// present one word and hold it until taken
	task automatic push_word(logic c, logic signed [31:0] k, logic [10:0] p);
		cmd      <= c;
		new_key  <= k;
		position <= p;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		sent++;
		if (c == CMD_INSERT) begin
			if (fill < DEPTH)
				fill++;
			else
				full_hits++;
		end else if (p == 0 || p > fill) begin
			bad_hits++;
		end
		if (idle_on && $urandom_range(0, 99) < 38) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_key();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $signed($urandom_range(0, 15)) - 8;
			2: return $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	function automatic logic [10:0] pick_slot();
		if (fill > 0 && $urandom_range(0, 99) < 85)
			return 11'($urandom_range(1, fill));
		return 11'($urandom_range(0, 2047));
	endfunction

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cmd      = CMD_INSERT;
		new_key  = '0;
		position = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty heap, extreme keys, root ties, bad slots
		push_word(CMD_UPDATE, 32'sd3, 11'd1);
		push_word(CMD_UPDATE, 32'sd3, 11'd0);
		push_word(CMD_INSERT, 32'sd0, 11'd0);
		push_word(CMD_INSERT, KEY_MAX, 11'd2047);
		push_word(CMD_INSERT, KEY_MIN, 11'd0);
		push_word(CMD_INSERT, -32'sd1, 11'd0);
		push_word(CMD_INSERT, KEY_MAX, 11'd0);
		push_word(CMD_UPDATE, KEY_MAX, 11'd1);
		push_word(CMD_UPDATE, KEY_MIN, 11'd2);
		push_word(CMD_UPDATE, KEY_MAX, 11'd3);
		push_word(CMD_UPDATE, 32'sd7, 11'd6);
		push_word(CMD_UPDATE, 32'sd7, 11'd2047);
		push_word(CMD_INSERT, 32'sd5, 11'd0);
		push_word(CMD_INSERT, 32'sd5, 11'd0);
		push_word(CMD_INSERT, 32'sd5, 11'd0);
		push_word(CMD_UPDATE, -32'sd5, 11'd1);
		push_word(CMD_UPDATE, 32'sd5, 11'd1);
		push_word(CMD_UPDATE, KEY_MIN, 11'd1);

		// random: insert-heavy, then topped up with inserts until the heap reaches capacity
		for (int i = 0; i < 900; i++) begin
			idle_on = !(i >= 300 && i < 450);
			if ($urandom_range(0, 99) < 90)
				push_word(CMD_INSERT, pick_key(), 11'($urandom_range(0, 2047)));
			else
				push_word(CMD_UPDATE, pick_key(), pick_slot());
		end
		idle_on = 1'b1;
		while (fill < DEPTH)
			push_word(CMD_INSERT, pick_key(), 11'd0);
		for (int i = 0; i < 20; i++)
			push_word($urandom_range(0, 1) ? CMD_INSERT : CMD_UPDATE, pick_key(),
				$urandom_range(0, 1) ? 11'd1024 : pick_slot());
		push_word(CMD_UPDATE, 32'sd1, 11'd1025);
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);

		$display("Sent %0d words (%0d refused as full, %0d bad slots), checked %0d results.",
			sent, full_hits, bad_hits, received);
		$display("Heap filled to %0d entries with key ties, extremes and long stalls.", fill);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/ihp_pkg.sv
hdl/ihp_front.sv
hdl/ihp_back.sv
hdl/indexed_max_heap_top.sv
verif/ihp_checker.sv
verif/tb_indexed_max_heap_top.sv
